FILE: sv/pms_pkg.sv
package pms_pkg;

	localparam int CMD_W       = 3;
	localparam int CH_W        = 8;
	localparam int SIDX_W      = 4;
	localparam int PER_W       = 16;
	localparam int ID_W        = 29;
	localparam int LEN_W       = 7;
	localparam int KIND_W      = 2;
	localparam int STAT_W      = 2;
	localparam int SCH_W       = 2;
	localparam int CNT_W       = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int MAX_CH      = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CNT_W-1:0] ENABLE_LEAD     = 32'd7;
	localparam logic [CNT_W-1:0] DISABLE_LEAD    = 32'd3;
	localparam logic [CFG_W-1:0] TICK_PERIOD_RST = 16'd10;
	localparam logic [CFG_W-1:0] START_DELAY_RST = 16'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK        = 3'd0,
		CMD_ENABLE      = 3'd1,
		CMD_DISABLE     = 3'd2,
		CMD_ENABLE_ALL  = 3'd3,
		CMD_DISABLE_ALL = 3'd4,
		CMD_LOAD        = 3'd5
	} pms_cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS    = 2'd0,
		KIND_SEND      = 2'd1,
		KIND_TICK_DONE = 2'd2
	} pms_kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK          = 2'd0,
		STAT_BAD_CHANNEL = 2'd1,
		STAT_NO_SLOT     = 2'd2
	} pms_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICK_PERIOD = 1'b0,
		REG_START_DELAY = 1'b1
	} pms_reg_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_CHAN,
		OP_ALL,
		OP_LOAD,
		OP_REPLY
	} pms_opc_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_DONE
	} pms_state_t;

	typedef struct packed {
		pms_opc_t           opc;
		logic               awake;
		logic               enable;
		pms_status_t        status;
		logic [SCH_W-1:0]   ch;
		logic [SIDX_W-1:0]  slot;
		logic [PER_W-1:0]   period;
		logic [ID_W-1:0]    id;
		logic [LEN_W-1:0]   len;
	} pms_op_t;

	typedef struct packed {
		logic [PER_W-1:0] period;
		logic [CNT_W-1:0] count;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
		logic [SCH_W-1:0] ch;
	} pms_slot_t;

	typedef struct packed {
		pms_kind_t         kind;
		pms_status_t       status;
		logic [SIDX_W-1:0] fired_slot;
		logic [ID_W-1:0]   send_id;
		logic [LEN_W-1:0]  send_length;
		logic [SCH_W-1:0]  send_channel;
		logic              last;
	} pms_rsp_t;

endpackage

FILE: sv/pms_req_if.sv
interface pms_req_if;
	import pms_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic              awake;
	logic [CH_W-1:0]   channel;
	logic [SIDX_W-1:0] slot_index;
	logic [PER_W-1:0]  period_ms;
	logic [ID_W-1:0]   message_id;
	logic [LEN_W-1:0]  byte_count;

	modport source (
		output valid, cmd, awake, channel, slot_index, period_ms, message_id, byte_count,
		input  ready
	);

	modport sink (
		input  valid, cmd, awake, channel, slot_index, period_ms, message_id, byte_count,
		output ready
	);

endinterface

FILE: sv/pms_rsp_if.sv
interface pms_rsp_if;
	import pms_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [STAT_W-1:0] status;
	logic [SIDX_W-1:0] fired_slot;
	logic [ID_W-1:0]   send_id;
	logic [LEN_W-1:0]  send_length;
	logic [SCH_W-1:0]  send_channel;
	logic              last;

	modport source (
		output valid, kind, status, fired_slot, send_id, send_length, send_channel, last,
		input  ready
	);

	modport sink (
		input  valid, kind, status, fired_slot, send_id, send_length, send_channel, last,
		output ready
	);

endinterface

FILE: sv/pms_cfg_if.sv
interface pms_cfg_if;
	import pms_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] addr;
	logic [CFG_W-1:0]     data;

	modport source (
		output valid, addr, data,
		input  ready
	);

	modport sink (
		input  valid, addr, data,
		output ready
	);

endinterface

FILE: sv/pms_ram.sv
module pms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/pms_queue.sv
module pms_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pms_pkg::pms_op_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output pms_pkg::pms_op_t head
);
	import pms_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	pms_op_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/pms_front.sv
module pms_front #(
	parameter int NUM_SLOTS    = 16,
	parameter int NUM_CHANNELS = 3
) (
	pms_req_if.sink          req,
	input  logic             q_full,
	output logic             push,
	output pms_pkg::pms_op_t op
);
	import pms_pkg::*;

	logic ch_bad;
	logic slot_bad;

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	assign ch_bad   = 32'(req.channel) >= 32'(NUM_CHANNELS);
	assign slot_bad = 32'(req.slot_index) >= 32'(NUM_SLOTS);

	always_comb begin
		op        = '0;
		op.opc    = OP_REPLY;
		op.awake  = req.awake;
		op.status = STAT_OK;
		op.ch     = req.channel[SCH_W-1:0];
		op.slot   = req.slot_index;
		op.period = req.period_ms;
		op.id     = req.message_id;
		op.len    = req.byte_count;
		unique case (pms_cmd_t'(req.cmd))
			CMD_TICK: begin
				op.opc = OP_TICK;
			end
			CMD_ENABLE, CMD_DISABLE: begin
				op.enable = (pms_cmd_t'(req.cmd) == CMD_ENABLE);
				if (ch_bad) begin
					op.status = STAT_BAD_CHANNEL;
				end else begin
					op.opc = OP_CHAN;
				end
			end
			CMD_ENABLE_ALL, CMD_DISABLE_ALL: begin
				op.opc    = OP_ALL;
				op.enable = (pms_cmd_t'(req.cmd) == CMD_ENABLE_ALL);
			end
			CMD_LOAD: begin
				if (ch_bad) begin
					op.status = STAT_BAD_CHANNEL;
				end else if (!slot_bad) begin
					op.opc = OP_LOAD;
				end
			end
			default: begin
				op.opc = OP_REPLY;
			end
		endcase
	end

endmodule

FILE: sv/pms_back.sv
module pms_back #(
	parameter int NUM_SLOTS    = 16,
	parameter int NUM_CHANNELS = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  pms_pkg::pms_op_t q_head,
	output logic             pop,
	pms_cfg_if.sink          cfg,
	pms_rsp_if.source        rsp
);
	import pms_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [MAX_CH-1:0] ALL_CH    = MAX_CH'((1 << NUM_CHANNELS) - 1);

	pms_state_t  state_q, state_d;
	pms_op_t     op_q;
	pms_status_t status_q;
	logic [CFG_W-1:0] tick_period_q;
	logic [CFG_W-1:0] start_delay_q;
	logic [MAX_CH-1:0] en_q;
	logic was_asleep_q;
	logic [MAX_CH-1:0][NUM_SLOTS-1:0] chmask_q;
	logic issue_more_q;
	logic [SLOT_W-1:0] issue_idx_q;
	logic rd_vld_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	logic out_valid_q;
	pms_rsp_t out_q;

	logic ram_we;
	logic ram_re;
	logic [SLOT_W-1:0] ram_waddr;
	pms_slot_t ram_wdata;
	logic [$bits(pms_slot_t)-1:0] ram_rdata;
	pms_slot_t slot;

	logic out_free;
	logic slot_used;
	logic found;
	logic needs_scan;
	logic scan_done;
	logic advance;
	logic send_req;
	logic fire;
	logic wr_cond;
	logic emit;
	pms_rsp_t emit_data;
	logic [CNT_W-1:0] per32;
	logic [CNT_W-1:0] lead;
	logic [CNT_W-1:0] base;
	logic [CNT_W-1:0] sum;
	logic [CNT_W-1:0] new_count;
	logic [SLOT_W+SIDX_W-1:0] load_ext;
	logic [SLOT_W-1:0] load_idx;
	logic [SLOT_W+SIDX_W-1:0] fired_ext;
	pms_slot_t load_entry;

	pms_ram #(
		.WIDTH ($bits(pms_slot_t)),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (issue_idx_q),
		.rdata (ram_rdata)
	);

	assign cfg.ready = 1'b1;
	assign slot      = pms_slot_t'(ram_rdata);
	assign out_free  = !out_valid_q || rsp.ready;
	assign found     = |chmask_q[op_q.ch];
	assign load_ext  = {{SLOT_W{1'b0}}, op_q.slot};
	assign load_idx  = load_ext[SLOT_W-1:0];
	assign fired_ext = {{SIDX_W{1'b0}}, rd_idx_s1};
	assign scan_done = (state_q == S_SCAN) && !issue_more_q && !rd_vld_s1;

	always_comb begin
		slot_used = 1'b0;
		for (int c = 0; c < MAX_CH; c++) begin
			slot_used = slot_used | chmask_q[c][rd_idx_s1];
		end
	end

	always_comb begin
		needs_scan = 1'b0;
		unique case (op_q.opc)
			OP_TICK:  needs_scan = op_q.awake;
			OP_CHAN:  needs_scan = found;
			OP_ALL:   needs_scan = 1'b1;
			default:  needs_scan = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					state_d = S_START;
				end
			end
			S_START: begin
				state_d = needs_scan ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		per32 = {{(CNT_W - PER_W){1'b0}}, slot.period};
		lead  = op_q.enable ? ENABLE_LEAD : DISABLE_LEAD;
		base  = was_asleep_q ? per32 - {{(CNT_W - CFG_W){1'b0}}, start_delay_q} : slot.count;
		sum   = base + {{(CNT_W - CFG_W){1'b0}}, tick_period_q};
		fire  = en_q[slot.ch] && (sum >= per32);

		wr_cond   = 1'b0;
		new_count = per32 - lead;
		unique case (op_q.opc)
			OP_TICK: begin
				wr_cond   = slot_used;
				new_count = en_q[slot.ch] ? (fire ? '0 : sum) : base;
			end
			OP_CHAN: wr_cond = slot_used && (slot.ch == op_q.ch);
			OP_ALL:  wr_cond = slot_used;
			default: wr_cond = 1'b0;
		endcase

		send_req = (state_q == S_SCAN) && rd_vld_s1 && slot_used &&
			(op_q.opc == OP_TICK) && fire;
		advance  = (state_q == S_SCAN) && !(send_req && !out_free);
		ram_re   = advance && issue_more_q;

		load_entry.period = op_q.period;
		load_entry.count  = (op_q.period != '0) ?
			{{(CNT_W - PER_W){1'b0}}, op_q.period} -
			{{(CNT_W - CFG_W){1'b0}}, start_delay_q} : '0;
		load_entry.id     = op_q.id;
		load_entry.len    = op_q.len;
		load_entry.ch     = op_q.ch;

		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = slot;
		ram_wdata.count = new_count;
		if (state_q == S_START && op_q.opc == OP_LOAD) begin
			ram_we    = 1'b1;
			ram_waddr = load_idx;
			ram_wdata = load_entry;
		end else if (advance && rd_vld_s1 && wr_cond) begin
			ram_we = 1'b1;
		end

		pop       = (state_q == S_IDLE) && !q_empty;
		emit      = 1'b0;
		emit_data = '0;
		if (send_req) begin
			emit                   = out_free;
			emit_data.kind         = KIND_SEND;
			emit_data.status       = STAT_OK;
			emit_data.fired_slot   = fired_ext[SIDX_W-1:0];
			emit_data.send_id      = slot.id;
			emit_data.send_length  = slot.len;
			emit_data.send_channel = slot.ch;
		end else if (state_q == S_DONE) begin
			emit             = out_free;
			emit_data.kind   = (op_q.opc == OP_TICK) ? KIND_TICK_DONE : KIND_STATUS;
			emit_data.status = status_q;
			emit_data.last   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= q_head;
		end
		if (state_q == S_START) begin
			status_q <= (op_q.opc == OP_CHAN && !found) ? STAT_NO_SLOT : op_q.status;
		end
		if (advance) begin
			rd_idx_s1 <= issue_idx_q;
		end
		if (emit) begin
			out_q <= emit_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tick_period_q <= TICK_PERIOD_RST;
			start_delay_q <= START_DELAY_RST;
			en_q          <= '0;
			was_asleep_q  <= 1'b0;
			chmask_q      <= '0;
			issue_more_q  <= 1'b0;
			issue_idx_q   <= '0;
			rd_vld_s1     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid) begin
				unique case (pms_reg_t'(cfg.addr))
					REG_TICK_PERIOD: tick_period_q <= cfg.data;
					REG_START_DELAY: start_delay_q <= cfg.data;
					default:         tick_period_q <= tick_period_q;
				endcase
			end

			if (state_q == S_START) begin
				if (needs_scan) begin
					issue_more_q <= 1'b1;
					issue_idx_q  <= '0;
				end
				if (op_q.opc == OP_LOAD) begin
					for (int c = 0; c < MAX_CH; c++) begin
						chmask_q[c][load_idx] <= (SCH_W'(c) == op_q.ch) && (op_q.period != '0);
					end
				end
			end

			if (advance) begin
				rd_vld_s1 <= issue_more_q;
			end
			if (ram_re) begin
				issue_idx_q <= issue_idx_q + 1'b1;
				if (issue_idx_q == LAST_SLOT) begin
					issue_more_q <= 1'b0;
				end
			end

			if (state_q == S_DONE && out_free) begin
				unique case (op_q.opc)
					OP_TICK: was_asleep_q <= !op_q.awake;
					OP_CHAN: begin
						if (status_q == STAT_OK) begin
							en_q[op_q.ch] <= op_q.enable;
						end
					end
					OP_ALL:  en_q <= op_q.enable ? ALL_CH : '0;
					default: en_q <= en_q;
				endcase
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = out_q.kind;
	assign rsp.status       = out_q.status;
	assign rsp.fired_slot   = out_q.fired_slot;
	assign rsp.send_id      = out_q.send_id;
	assign rsp.send_length  = out_q.send_length;
	assign rsp.send_channel = out_q.send_channel;
	assign rsp.last         = out_q.last;

endmodule

FILE: sv/periodic_message_scheduler_top.sv
// Channel  Direction  Contents
// req      in         cmd, awake, channel, slot_index, period_ms, message_id, byte_count
// rsp      out        kind, status, fired_slot, send_id, send_length, send_channel, last
// cfg      in         register write: addr (0 tick_period, 1 start_delay), data
//
// An awake tick, an enable_all or disable_all, and an enable or disable of a channel that
// owns slots scan the slot table, stalling while rsp stalls; the scan reads the slot RAM
// once per slot over one read port. Other commands skip the scan.
// Reset is asynchronous; the slot table comes up unused at once through per-slot flops.
// A two-entry command queue lets req keep accepting until it is full while rsp is stalled.
module periodic_message_scheduler_top #(
	parameter int NUM_SLOTS    = 16,
	parameter int NUM_CHANNELS = 3
) (
	input logic       clk,
	input logic       arst_n,
	pms_req_if.sink   req,
	pms_rsp_if.source rsp,
	pms_cfg_if.sink   cfg
);
	import pms_pkg::*;

	logic    push;
	logic    q_full;
	logic    q_empty;
	logic    pop;
	pms_op_t push_op;
	pms_op_t q_head;

	pms_front #(
		.NUM_SLOTS    (NUM_SLOTS),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_front (
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.op     (push_op)
	);

	pms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_op),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	pms_back #(
		.NUM_SLOTS    (NUM_SLOTS),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.pop     (pop),
		.cfg     (cfg),
		.rsp     (rsp)
	);

endmodule
